@@ rtl/dsrfg_pkg.sv @@
// Package for the dual-stream rate and freshness gate.
// Widths, reset values, register indexes and shared types; no dependencies.
`default_nettype none

package dsrfg_pkg;

    localparam int TIME_BITS_DEF = 40;
    localparam int TIME_FIELD_W  = 40;
    localparam int RATE_W        = 28;
    localparam int TIMEOUT_W     = 24;
    localparam int SMOOTH_W      = 9;
    localparam int MODE_W        = 2;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 28;
    localparam int ACC_W         = RATE_W + SMOOTH_W;

    localparam logic [RATE_W-1:0]    RATE_SCALE      = 28'd256000000;
    localparam logic [RATE_W-1:0]    MIN_RATE_RST    = 28'd12800;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST     = 24'd100000;
    localparam logic [SMOOTH_W-1:0]  SMOOTH_RST      = 9'd230;
    localparam logic [SMOOTH_W-1:0]  SMOOTH_ONE      = 9'd256;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_RATE = 2'd0,
        CFG_TIMEOUT  = 2'd1,
        CFG_SMOOTH   = 2'd2
    } cfg_idx_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_ARRIVE_A = 2'd0,
        MODE_ARRIVE_B = 2'd1,
        MODE_TICK     = 2'd2
    } mode_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

`default_nettype wire

@@ rtl/dsrfg_div.sv @@
// Radix-2 restoring divider, one quotient bit per cycle.
// Uses dsrfg_pkg for widths and the status struct.
`default_nettype none

module dsrfg_div (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         start,
    input  wire logic [dsrfg_pkg::RATE_W-1:0] dividend,
    input  wire logic [dsrfg_pkg::RATE_W-1:0] divisor,
    output logic      [dsrfg_pkg::RATE_W-1:0] quotient,
    output dsrfg_pkg::div_stat_t              stat
);
    import dsrfg_pkg::*;

    localparam int CNT_W = $clog2(RATE_W);

    logic [CNT_W-1:0]  count_reg, count_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [RATE_W-1:0] rem_reg, rem_next;
    logic [RATE_W-1:0] quo_reg, quo_next;
    logic [RATE_W-1:0] dvs_reg, dvs_next;
    logic [RATE_W+1:0] trial;

    always_comb begin
        trial      = {1'b0, rem_reg, quo_reg[RATE_W-1]} - {2'b00, dvs_reg};
        count_next = count_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        dvs_next   = dvs_reg;
        if (start) begin
            busy_next  = 1'b1;
            count_next = CNT_W'(RATE_W - 1);
            rem_next   = '0;
            quo_next   = dividend;
            dvs_next   = divisor;
        end else if (busy_reg) begin
            // subtract when the partial remainder covers the divisor
            if (!trial[RATE_W+1]) begin
                rem_next = trial[RATE_W-1:0];
                quo_next = {quo_reg[RATE_W-2:0], 1'b1};
            end else begin
                rem_next = {rem_reg[RATE_W-2:0], quo_reg[RATE_W-1]};
                quo_next = {quo_reg[RATE_W-2:0], 1'b0};
            end
            if (count_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                count_next = count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end else begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

`default_nettype wire

@@ rtl/dual_stream_rate_freshness_gate.sv @@
// Dual-stream rate and freshness gate: sequencer, state and shared multiplier.
// Depends on dsrfg_pkg and dsrfg_div.
//
// Usage: each beat on the s_ channel is an arrival on stream A (mode 0), an
// arrival on stream B (mode 1) or a gate tick (mode 2), with a microsecond
// timestamp. Mode 3 beats are taken and dropped. Arrivals produce no result;
// each tick produces one beat on the m_ channel with publish, freshness flags
// and both smoothed rates in Q8 Hz.
// Sequence: an arrival that updates a rate holds s_ready low from its accept
// through the interval and divider start, 28 divide steps, the divider's done
// strobe and two multiply-accumulate steps (an interval too long for the divider
// skips the divide and folds in a zero rate); a tick holds it until its result loads.
// The divider sets the throughput: one item at a time, s_ready only when idle.
// A result sits in an output register; the block goes on accepting arrivals
// while it waits. A tick that finishes while that register is still full holds
// until m_ready frees it.
// Reset (synchronous, aresetn low) clears all stream state and restores the
// configuration registers; cfg writes are taken in any cycle.
`default_nettype none

module dual_stream_rate_freshness_gate #(
    parameter int TIME_BITS = dsrfg_pkg::TIME_BITS_DEF
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_we,
    input  wire logic [dsrfg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [dsrfg_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic [dsrfg_pkg::MODE_W-1:0]       s_mode,
    input  wire logic [dsrfg_pkg::TIME_FIELD_W-1:0] s_time_us,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic                                    m_publish,
    output logic                                    m_fresh_a,
    output logic                                    m_fresh_b,
    output logic      [dsrfg_pkg::RATE_W-1:0]       m_avg_rate_a,
    output logic      [dsrfg_pkg::RATE_W-1:0]       m_avg_rate_b
);
    import dsrfg_pkg::*;

    localparam int TW = (TIME_BITS < TIME_FIELD_W) ? TIME_BITS : TIME_FIELD_W;

    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_ARRIVE  = 6'b000010,
        ST_DIV     = 6'b000100,
        ST_MUL_OLD = 6'b001000,
        ST_MUL_NEW = 6'b010000,
        ST_TICK    = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [RATE_W-1:0]    min_rate_reg;
    logic [TIMEOUT_W-1:0] timeout_reg;
    logic [SMOOTH_W-1:0]  smooth_reg;

    logic [TW-1:0]     last_reg [2];
    logic [RATE_W-1:0] rate_reg [2];
    logic [1:0]        seen_reg;

    logic [TW-1:0]     now_reg;
    logic              sel_reg, sel_next;
    logic              fresh_a_reg, fresh_a_next;
    logic [RATE_W-1:0] inst_reg, inst_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;

    logic              m_valid_reg;
    logic              m_publish_reg, m_fresh_a_reg, m_fresh_b_reg;
    logic [RATE_W-1:0] m_rate_a_reg, m_rate_b_reg;

    // shared datapath
    logic [TW:0]          diff;
    logic                 later;
    logic                 fresh_cur;
    logic                 need_div;
    logic                 big_dt;
    logic [SMOOTH_W-1:0]  w_eff;
    logic [SMOOTH_W-1:0]  mul_a;
    logic [RATE_W-1:0]    mul_b;
    logic [ACC_W-1:0]     prod;
    logic [ACC_W-1:0]     acc_sum;
    logic                 out_free;
    logic                 accept;
    logic                 div_start;
    logic [RATE_W-1:0]    div_quo;
    div_stat_t            div_stat;

    assign accept   = s_valid && s_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_ready;

    assign diff      = {1'b0, now_reg} - {1'b0, last_reg[sel_reg]};
    assign later     = !diff[TW] && (diff[TW-1:0] != '0);
    assign big_dt    = (diff[TW-1:RATE_W] != '0);
    assign need_div  = seen_reg[sel_reg] && later && !big_dt;
    assign fresh_cur = seen_reg[sel_reg] &&
                       (!later || diff[TW-1:0] <= {{(TW-TIMEOUT_W){1'b0}}, timeout_reg});

    assign w_eff   = (smooth_reg > SMOOTH_ONE) ? SMOOTH_ONE : smooth_reg;
    assign mul_a   = (state_reg == ST_MUL_OLD) ? w_eff : SMOOTH_ONE - w_eff;
    assign mul_b   = (state_reg == ST_MUL_OLD) ? rate_reg[sel_reg] : inst_reg;
    assign prod    = {{RATE_W{1'b0}}, mul_a} * {{SMOOTH_W{1'b0}}, mul_b};
    assign acc_sum = acc_reg + prod + ACC_W'(128);

    assign div_start = (state_reg == ST_ARRIVE) && need_div;

    dsrfg_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (RATE_SCALE),
        .divisor  (diff[RATE_W-1:0]),
        .quotient (div_quo),
        .stat     (div_stat)
    );

    always_comb begin
        state_next   = state_reg;
        sel_next     = sel_reg;
        fresh_a_next = fresh_a_reg;
        inst_next    = inst_reg;
        acc_next     = acc_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    sel_next = s_mode[0];
                    case (s_mode)
                        MODE_ARRIVE_A, MODE_ARRIVE_B: state_next = ST_ARRIVE;
                        MODE_TICK: begin
                            sel_next   = 1'b0;
                            state_next = ST_TICK;
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_ARRIVE: begin
                if (need_div) begin
                    state_next = ST_DIV;
                end else if (seen_reg[sel_reg] && later) begin
                    // interval too long for a nonzero rate
                    inst_next  = '0;
                    state_next = ST_MUL_OLD;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    inst_next  = div_quo;
                    state_next = ST_MUL_OLD;
                end
            end
            ST_MUL_OLD: begin
                acc_next   = prod;
                state_next = ST_MUL_NEW;
            end
            ST_MUL_NEW: begin
                state_next = ST_IDLE;
            end
            ST_TICK: begin
                if (!sel_reg) begin
                    fresh_a_next = fresh_cur;
                    sel_next     = 1'b1;
                end else if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_rate_reg <= MIN_RATE_RST;
            timeout_reg  <= TIMEOUT_RST;
            smooth_reg   <= SMOOTH_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_MIN_RATE: min_rate_reg <= cfg_wdata[RATE_W-1:0];
                CFG_TIMEOUT:  timeout_reg  <= cfg_wdata[TIMEOUT_W-1:0];
                CFG_SMOOTH:   smooth_reg   <= cfg_wdata[SMOOTH_W-1:0];
                default: ;
            endcase
        end
    end

    // stream state and sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            seen_reg    <= '0;
            last_reg[0] <= '0;
            last_reg[1] <= '0;
            rate_reg[0] <= '0;
            rate_reg[1] <= '0;
            sel_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
            if (state_reg == ST_ARRIVE) begin
                last_reg[sel_reg] <= now_reg;
                seen_reg[sel_reg] <= 1'b1;
            end
            if (state_reg == ST_MUL_NEW) begin
                rate_reg[sel_reg] <= acc_sum[RATE_W+7:8];
            end
        end
        if (accept) begin
            now_reg <= s_time_us[TW-1:0];
        end
        fresh_a_reg <= fresh_a_next;
        inst_reg    <= inst_next;
        acc_reg     <= acc_next;
    end

    // output register: load once the tick has checked stream B and the register is free, hold while stalled
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_TICK && sel_reg && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (state_reg == ST_TICK && sel_reg && out_free) begin
            m_fresh_a_reg <= fresh_a_reg;
            m_fresh_b_reg <= fresh_cur;
            m_publish_reg <= fresh_a_reg && fresh_cur &&
                             (rate_reg[0] >= min_rate_reg) &&
                             (rate_reg[1] >= min_rate_reg);
            m_rate_a_reg  <= rate_reg[0];
            m_rate_b_reg  <= rate_reg[1];
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_publish    = m_publish_reg;
    assign m_fresh_a    = m_fresh_a_reg;
    assign m_fresh_b    = m_fresh_b_reg;
    assign m_avg_rate_a = m_rate_a_reg;
    assign m_avg_rate_b = m_rate_b_reg;

endmodule

`default_nettype wire

@@ tb/sv/tb_dual_stream_rate_freshness_gate.sv @@
// Testbench for dual_stream_rate_freshness_gate: directed and random beats, each tick report
// checked against an in-bench model of stream rates, freshness and publish.
// Depends on dsrfg_pkg and the gate RTL.

module tb_dual_stream_rate_freshness_gate;
    timeunit 1ns;
    timeprecision 1ps;

    import dsrfg_pkg::*;

    localparam int RESET_CYCLES  = 12;
    localparam int SETTLE_CYCLES = 40;
    localparam int QUIET_LIMIT   = 4000;
    localparam int MAX_REPORTED  = 10;
    localparam int STREAM_A      = 0;
    localparam int STREAM_B      = 1;
    localparam int MIX_BEATS     = 170;

    localparam logic [MODE_W-1:0]       MODE_UNUSED = 2'd3;
    localparam logic [TIME_FIELD_W-1:0] TIME_MAX    = '1;
    localparam logic [CFG_DATA_W-1:0]   DATA_MAX    = '1;

    typedef enum int {
        MIX_REALISTIC,
        MIX_ALL_LOW,
        MIX_ALL_HIGH,
        MIX_OVER_UNITY
    } cfg_mix_t;

    typedef struct packed {
        logic              publish;
        logic              fresh_a;
        logic              fresh_b;
        logic [RATE_W-1:0] rate_a;
        logic [RATE_W-1:0] rate_b;
    } gate_report_t;

    logic                    aclk      = 1'b0;
    logic                    aresetn   = 1'b0;
    logic                    cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_wdata = '0;
    logic                    s_valid   = 1'b0;
    logic                    s_ready;
    logic [MODE_W-1:0]       s_mode    = '0;
    logic [TIME_FIELD_W-1:0] s_time_us = '0;
    logic                    m_valid;
    logic                    m_ready   = 1'b0;
    logic                    m_publish;
    logic                    m_fresh_a;
    logic                    m_fresh_b;
    logic [RATE_W-1:0]       m_avg_rate_a;
    logic [RATE_W-1:0]       m_avg_rate_b;

    // Model state and register copies
    logic [TIME_FIELD_W-1:0] last_seen_us [2] = '{default: '0};
    logic [RATE_W-1:0]       avg_rate     [2] = '{default: '0};
    logic                    stream_seen  [2] = '{default: 1'b0};
    logic [RATE_W-1:0]       min_rate_cfg = MIN_RATE_RST;
    logic [TIMEOUT_W-1:0]    timeout_cfg  = TIMEOUT_RST;
    logic [SMOOTH_W-1:0]     smooth_cfg   = SMOOTH_RST;
    gate_report_t            pending_reports [$];

    logic [TIME_FIELD_W-1:0] clock_us = '0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int beats_sent     = 0;
    int reports_seen   = 0;
    int publish_seen   = 0;
    int mismatches     = 0;
    int quiet_cycles   = 0;

    dual_stream_rate_freshness_gate #(
        .TIME_BITS(TIME_BITS_DEF)
    ) u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_mode      (s_mode),
        .s_time_us   (s_time_us),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_publish   (m_publish),
        .m_fresh_a   (m_fresh_a),
        .m_fresh_b   (m_fresh_b),
        .m_avg_rate_a(m_avg_rate_a),
        .m_avg_rate_b(m_avg_rate_b)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic logic stream_is_fresh(input int s, input logic [TIME_FIELD_W-1:0] now);
        if (!stream_seen[s])
            return 1'b0;
        // a clock that runs backwards counts as a negative age
        if (now <= last_seen_us[s])
            return 1'b1;
        return (now - last_seen_us[s]) <= timeout_cfg;
    endfunction

    task automatic fold_stream_rate(input int s, input logic [TIME_FIELD_W-1:0] now);
        logic [63:0] interval;
        logic [63:0] inst;
        logic [63:0] weight;
        logic [63:0] acc;
        if (stream_seen[s] && now > last_seen_us[s]) begin
            interval = now - last_seen_us[s];
            inst     = 64'(RATE_SCALE) / interval;
            weight   = (smooth_cfg > SMOOTH_ONE) ? 64'(SMOOTH_ONE) : 64'(smooth_cfg);
            acc      = weight * avg_rate[s] + (64'd256 - weight) * inst + 64'd128;
            avg_rate[s] = acc[RATE_W+7:8];
        end
        last_seen_us[s] = now;
        stream_seen[s]  = 1'b1;
    endtask

    task automatic compute_gate_report(input logic [MODE_W-1:0] mode,
                                       input logic [TIME_FIELD_W-1:0] now);
        gate_report_t rep;
        case (mode)
            MODE_ARRIVE_A: fold_stream_rate(STREAM_A, now);
            MODE_ARRIVE_B: fold_stream_rate(STREAM_B, now);
            MODE_TICK: begin
                rep.fresh_a = stream_is_fresh(STREAM_A, now);
                rep.fresh_b = stream_is_fresh(STREAM_B, now);
                rep.rate_a  = avg_rate[STREAM_A];
                rep.rate_b  = avg_rate[STREAM_B];
                rep.publish = rep.fresh_a && rep.fresh_b &&
                              avg_rate[STREAM_A] >= min_rate_cfg &&
                              avg_rate[STREAM_B] >= min_rate_cfg;
                pending_reports.push_back(rep);
            end
            default: ; // drop unused mode
        endcase
    endtask

    function automatic void note_mismatch(input string what, input logic [63:0] want,
                                          input logic [63:0] got);
        mismatches++;
        if (mismatches <= MAX_REPORTED)
            $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, what, want, got);
    endfunction

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        gate_report_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_reports.size() == 0) begin
                note_mismatch("result beat with none pending, count", 0, 1);
            end else begin
                want = pending_reports.pop_front();
                reports_seen++;
                if (want.publish)
                    publish_seen++;
                if (m_publish !== want.publish)
                    note_mismatch("publish", want.publish, m_publish);
                if (m_fresh_a !== want.fresh_a)
                    note_mismatch("fresh_a", want.fresh_a, m_fresh_a);
                if (m_fresh_b !== want.fresh_b)
                    note_mismatch("fresh_b", want.fresh_b, m_fresh_b);
                if (m_avg_rate_a !== want.rate_a)
                    note_mismatch("avg_rate_a", want.rate_a, m_avg_rate_a);
                if (m_avg_rate_b !== want.rate_b)
                    note_mismatch("avg_rate_b", want.rate_b, m_avg_rate_b);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no beat accepted for %0d cycles", QUIET_LIMIT);
            $display("tb_dual_stream_rate_freshness_gate: done, errors");
            $finish;
        end
    end

    task automatic send_beat(input logic [MODE_W-1:0] mode,
                             input logic [TIME_FIELD_W-1:0] stamp);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_mode    <= mode;
        s_time_us <= stamp;
        do @(posedge aclk); while (!s_ready);
        compute_gate_report(mode, stamp);
        beats_sent++;
    endtask

    // Hold the sender until every report is back, then let a slow arrival finish.
    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_one(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        case (idx)
            CFG_MIN_RATE: min_rate_cfg = data;
            CFG_TIMEOUT:  timeout_cfg  = data[TIMEOUT_W-1:0];
            CFG_SMOOTH:   smooth_cfg   = data[SMOOTH_W-1:0];
            default: ;
        endcase
    endtask

    task automatic write_registers(input logic [CFG_DATA_W-1:0] min_rate,
                                   input logic [CFG_DATA_W-1:0] timeout,
                                   input logic [CFG_DATA_W-1:0] smooth);
        write_one(CFG_MIN_RATE, min_rate);
        write_one(CFG_TIMEOUT, timeout);
        write_one(CFG_SMOOTH, smooth);
        cfg_we <= 1'b0;
    endtask

    // Reset values of the registers: boundaries of age, first arrivals, zero and
    // one microsecond intervals, backwards time, unused mode.
    task automatic test_reset_state();
        send_beat(MODE_TICK, '0);
        send_beat(MODE_ARRIVE_A, '0);
        send_beat(MODE_ARRIVE_B, '0);
        send_beat(MODE_TICK, '0);
        send_beat(MODE_ARRIVE_A, '0);
        send_beat(MODE_ARRIVE_A, 40'd1);
        send_beat(MODE_ARRIVE_B, 40'd1);
        send_beat(MODE_TICK, 40'd100001);
        send_beat(MODE_TICK, 40'd100002);
        send_beat(MODE_ARRIVE_A, TIME_MAX);
        send_beat(MODE_TICK, 40'd5);
        send_beat(MODE_ARRIVE_B, 40'd5);
        send_beat(MODE_UNUSED, TIME_MAX);
        send_beat(MODE_TICK, TIME_MAX);
    endtask

    // Zero timeout and weight, then full-scale floor and timeout with unit weight, then a weight above one.
    task automatic test_register_extremes();
        drain_results();
        write_registers('0, '0, '0);
        send_beat(MODE_ARRIVE_A, 40'd10);
        send_beat(MODE_ARRIVE_A, 40'd11);
        send_beat(MODE_ARRIVE_B, 40'd11);
        send_beat(MODE_TICK, 40'd11);
        send_beat(MODE_TICK, 40'd12);
        drain_results();
        write_registers(DATA_MAX, DATA_MAX, CFG_DATA_W'(SMOOTH_ONE));
        send_beat(MODE_ARRIVE_A, 40'd20);
        send_beat(MODE_TICK, 40'd20);
        drain_results();
        write_registers('0, DATA_MAX, DATA_MAX);
        send_beat(MODE_ARRIVE_B, 40'd30);
        send_beat(MODE_TICK, 40'd30);
    endtask

    task automatic test_random_traffic(input int n_beats, input int idle_pct,
                                       input int stall_pct, input cfg_mix_t mix);
        logic [CFG_DATA_W-1:0]   min_rate;
        logic [CFG_DATA_W-1:0]   timeout;
        logic [CFG_DATA_W-1:0]   smooth;
        logic [MODE_W-1:0]       mode;
        int period;
        int pick;
        int tmo;
        drain_results();
        period   = $urandom_range(20, 30000);
        min_rate = CFG_DATA_W'((64'(RATE_SCALE) / period) * $urandom_range(32, 300) / 256);
        timeout  = {4'($urandom), 24'(period * $urandom_range(1, 8) +
                                      $urandom_range(0, period))};
        smooth   = CFG_DATA_W'($urandom_range(0, 256));
        if ($urandom_range(0, 3) == 0)
            smooth[CFG_DATA_W-1:SMOOTH_W] = 19'($urandom);
        case (mix)
            MIX_ALL_LOW: begin
                min_rate = '0;
                timeout  = '0;
                smooth   = '0;
            end
            MIX_ALL_HIGH: begin
                min_rate = DATA_MAX;
                timeout  = DATA_MAX;
                smooth   = CFG_DATA_W'(SMOOTH_ONE);
            end
            MIX_OVER_UNITY: smooth = CFG_DATA_W'($urandom_range(257, 511));
            default: ;
        endcase
        write_registers(min_rate, timeout, smooth);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        tmo = int'(timeout_cfg);
        for (int i = 0; i < n_beats; i++) begin
            if (i == n_beats / 2)
                drain_results();
            pick = $urandom_range(0, 99);
            if (pick < 40)
                mode = MODE_ARRIVE_A;
            else if (pick < 80)
                mode = MODE_ARRIVE_B;
            else if (pick < 97)
                mode = MODE_TICK;
            else
                mode = MODE_UNUSED;
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                clock_us += $urandom_range(0, period);
            end else if (pick < 65) begin
                clock_us += $urandom_range(0, 3);
            end else if (pick < 75) begin
                // same timestamp again
            end else if (pick < 85) begin
                // age one below, at, or one past the timeout
                clock_us = last_seen_us[$urandom_range(0, 1)] + timeout_cfg +
                           $urandom_range(0, 2) - 1;
                mode = MODE_TICK;
            end else if (pick < 90) begin
                clock_us -= $urandom_range(1, period);
            end else if (pick < 95) begin
                clock_us += $urandom_range(tmo / 2, tmo * 2 + 1);
            end else if (pick < 98) begin
                clock_us += $urandom;
            end else begin
                clock_us = TIME_FIELD_W'({$urandom, $urandom});
            end
            send_beat(mode, clock_us);
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_state();
        test_register_extremes();
        test_random_traffic(MIX_BEATS, 0, 0, MIX_REALISTIC);
        test_random_traffic(MIX_BEATS, 66, 0, MIX_REALISTIC);
        test_random_traffic(MIX_BEATS, 0, 66, MIX_ALL_LOW);
        test_random_traffic(MIX_BEATS, 12, 12, MIX_REALISTIC);
        test_random_traffic(MIX_BEATS, 0, 0, MIX_OVER_UNITY);
        test_random_traffic(MIX_BEATS, 66, 0, MIX_ALL_HIGH);
        test_random_traffic(MIX_BEATS, 0, 66, MIX_REALISTIC);
        test_random_traffic(MIX_BEATS, 12, 12, MIX_REALISTIC);
        drain_results();
        $display("run covered %0d input beats over eight register and idling mixes",
                 beats_sent);
        $display("%0d tick reports compared, %0d with publish set, %0d field mismatches",
                 reports_seen, publish_seen, mismatches);
        if (mismatches == 0 && pending_reports.size() == 0) begin
            $display("tb_dual_stream_rate_freshness_gate: done, clean");
        end else begin
            $display("tb_dual_stream_rate_freshness_gate: done, errors");
        end
        $finish;
    end

endmodule

@@ dual_stream_rate_freshness_gate.f @@
rtl/dsrfg_pkg.sv
rtl/dsrfg_div.sv
rtl/dual_stream_rate_freshness_gate.sv
tb/sv/tb_dual_stream_rate_freshness_gate.sv
